/* hw/rtl/frame_pacing_timer_macros.svh */
// Assertion macros for the frame pacing timer checker.
`ifndef FRAME_PACING_TIMER_MACROS_SVH
`define FRAME_PACING_TIMER_MACROS_SVH

// Condition implies consequence in the same cycle.
`define FPT_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error("frame pacing timer check failed");

// Condition implies consequence in the next cycle.
`define FPT_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error("frame pacing timer check failed");

`endif

/* hw/rtl/fpt_pkg.sv */
// Shared types and constants of the frame pacing timer.
package fpt_pkg;

    localparam int TIME_W  = 32;
    localparam int MS_W    = 16;
    localparam int RATE_W  = 24;
    localparam int NUM_W   = 34;
    localparam int DIFF_W  = 17;
    localparam int CNT_W   = 5;
    localparam int DIV_STEPS = 34;
    localparam int DCNT_W  = 6;

    localparam logic [CNT_W-1:0]  SER_LAST    = 5'd31;
    localparam logic [CNT_W-1:0]  DIFF_LAST   = 5'd16;
    localparam logic [RATE_W-1:0] RATE_MAX    = 24'hFFFFFF;
    localparam logic [17:0]       MS_PER_S_Q8 = 18'd256000;

    localparam logic [MS_W-1:0]   PERIOD_MS_RST   = 16'd16;
    localparam logic [MS_W-1:0]   PERIOD_FRAC_RST = 16'd43690;
    localparam logic [MS_W-1:0]   WINDOW_RST      = 16'd1;
    localparam logic [RATE_W-1:0] NOMINAL_RST     = 24'd15360;

    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [1:0] {
        CFG_PERIOD_MS   = 2'd0,
        CFG_PERIOD_FRAC = 2'd1,
        CFG_WINDOW      = 2'd2,
        CFG_NOMINAL     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* hw/rtl/fpt_div.sv */
// Serial restoring divider for the measured frame rate, one quotient bit per cycle.
module fpt_div
    import fpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_numer,
    input  logic [TIME_W-1:0] i_denom,
    output t_div_stat         o_stat,
    output logic [RATE_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_den;
    logic [NUM_W-1:0]  r_num;
    logic [RATE_W-1:0] r_q;
    logic              r_ovf;

    logic [TIME_W:0]   rem_sh;
    logic [TIME_W:0]   rem_sub;
    logic              q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_denom;
            r_num <= i_numer;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_q   <= {r_q[RATE_W-2:0], q_bit};
            r_ovf <= r_ovf | r_q[RATE_W-1];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_ovf ? RATE_MAX : r_q;

endmodule

/* hw/rtl/frame_pacing_timer.sv */
// Frame pacing timer: bit-serial wait computation and windowed frame rate measurement.
//
// Input channel (i_in_valid / o_in_ready) takes one request: i_op and i_now_ms.
// Output channel (o_out_valid / i_out_ready) returns one result per request:
// o_delay_ms, o_measured_fps_q8 and o_window_done.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must
// write it only while idle, which the block itself does not enforce. A write of the
// period clears the fractional accumulator.
// A restart or the first frame event goes straight to the output stage. Any other
// frame event runs two bit-serial passes (elapsed time and wait, then time sum and
// next start time); when it closes a window with a nonzero time sum, the serial
// divider then computes the rate. One request is worked on at a time, and the next
// is taken after its result has been issued to the output register.
// A finished result waits in the output register while a new request is taken.
// When the receiver stalls, the result holds and the block stops before
// delivering the next one.
// Reset restores the register defaults, clears the timing state and loads the
// reported rate from the nominal rate.
module frame_pacing_timer
    import fpt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  logic [TIME_W-1:0] i_now_ms,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [MS_W-1:0]   o_delay_ms,
    output logic [RATE_W-1:0] o_measured_fps_q8,
    output logic              o_window_done,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [RATE_W-1:0] i_cfg_data
);

    localparam int SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SHR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PASS1, ST_PASS2, ST_MUL, ST_DSTART, ST_DWAIT, ST_EMIT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;

    logic [MS_W-1:0]    r_period_ms;
    logic [MS_W-1:0]    r_period_frac;
    logic [MS_W-1:0]    r_window;
    logic [RATE_W-1:0]  r_nominal;

    logic               r_first;
    logic [TIME_W-1:0]  r_last;
    logic [FRAC_BITS-1:0] r_acc;
    logic [MS_W-1:0]    r_fc;
    logic [TIME_W-1:0]  r_tt;
    logic [RATE_W-1:0]  r_rate;
    logic               r_out_valid;

    logic [TIME_W-1:0]  r_sh_now;
    logic [TIME_W-1:0]  r_sh_el;
    logic [DIFF_W-1:0]  r_sh_p;
    logic [DIFF_W-1:0]  r_diff;
    logic [MS_W-1:0]    r_sh_d;
    logic               r_b1;
    logic               r_b2;
    logic [1:0]         r_c3;
    logic               r_cl;
    logic [MS_W-1:0]    r_delay;
    logic               r_done;
    logic [MS_W-1:0]    r_fc_next;
    logic [NUM_W-1:0]   r_numer;
    logic [TIME_W-1:0]  r_den;
    logic [MS_W-1:0]    r_out_delay;
    logic [RATE_W-1:0]  r_out_rate;
    logic               r_out_done;

    logic               accept;
    logic               emit_go;
    t_cfg_idx           cfg_idx;
    logic [FRAC_BITS-1:0] frac_step;
    logic [FRAC_BITS:0] frac_sum;
    logic [DIFF_W-1:0]  period_full;
    logic               e_bit;
    logic               b1_n;
    logic               d_bit;
    logic               b2_n;
    logic [MS_W-1:0]    delay_calc;
    logic [2:0]         sum3;
    logic [1:0]         sum_l;
    logic [TIME_W-1:0]  tt_sh;
    logic [TIME_W-1:0]  tt_new;
    logic [MS_W-1:0]    win;
    logic               win_close;
    logic               div_start;
    t_div_stat          div_stat;
    logic [RATE_W-1:0]  div_quot;

    assign accept    = i_in_valid && o_in_ready;
    assign emit_go   = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    assign cfg_idx   = t_cfg_idx'(i_cfg_idx);
    assign div_start = (r_state == ST_DSTART);

    always_comb begin
        frac_step = FRAC_BITS'(({{FRAC_BITS{1'b0}}, r_period_frac} << SHL) >> SHR);
        frac_sum  = {1'b0, r_acc} + {1'b0, frac_step};
        period_full = {1'b0, r_period_ms} + DIFF_W'(frac_sum[FRAC_BITS]);

        e_bit = r_sh_now[0] ^ r_last[0] ^ r_b1;
        b1_n  = (~r_sh_now[0] & r_last[0]) | (~(r_sh_now[0] ^ r_last[0]) & r_b1);
        d_bit = r_sh_p[0] ^ e_bit ^ r_b2;
        b2_n  = (~r_sh_p[0] & e_bit) | (~(r_sh_p[0] ^ e_bit) & r_b2);

        if (b2_n) begin
            delay_calc = '0;
        end else if (r_diff[DIFF_W-1]) begin
            delay_calc = '1;
        end else begin
            delay_calc = r_diff[MS_W-1:0];
        end

        sum3   = {2'b0, r_tt[0]} + {2'b0, r_sh_el[0]} + {2'b0, r_sh_d[0]} + {1'b0, r_c3};
        sum_l  = {1'b0, r_sh_now[0]} + {1'b0, r_sh_d[0]} + {1'b0, r_cl};
        tt_sh  = {sum3[0], r_tt[TIME_W-1:1]};
        tt_new = (sum3[2:1] != 2'd0) ? '1 : tt_sh;

        win       = (r_window == '0) ? WINDOW_RST : r_window;
        win_close = (r_fc_next >= win);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cnt         <= '0;
            r_period_ms   <= PERIOD_MS_RST;
            r_period_frac <= PERIOD_FRAC_RST;
            r_window      <= WINDOW_RST;
            r_nominal     <= NOMINAL_RST;
            r_first       <= 1'b1;
            r_last        <= '0;
            r_acc         <= '0;
            r_fc          <= '0;
            r_tt          <= '0;
            r_rate        <= NOMINAL_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (cfg_idx)
                    CFG_PERIOD_MS: begin
                        r_period_ms <= i_cfg_data[MS_W-1:0];
                        r_acc       <= '0;
                    end
                    CFG_PERIOD_FRAC: begin
                        r_period_frac <= i_cfg_data[MS_W-1:0];
                        r_acc         <= '0;
                    end
                    CFG_WINDOW:  r_window  <= i_cfg_data[MS_W-1:0];
                    CFG_NOMINAL: r_nominal <= i_cfg_data;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cnt <= '0;
                        priority if (i_op == OP_RESTART) begin
                            r_first <= 1'b1;
                            r_acc   <= '0;
                            r_fc    <= '0;
                            r_tt    <= '0;
                            r_rate  <= r_nominal;
                            r_last  <= i_now_ms;
                            r_state <= ST_EMIT;
                        end else if (r_first) begin
                            r_first <= 1'b0;
                            r_last  <= i_now_ms;
                            r_state <= ST_EMIT;
                        end else begin
                            r_acc   <= frac_sum[FRAC_BITS-1:0];
                            r_state <= ST_PASS1;
                        end
                    end
                end
                ST_PASS1: begin
                    r_last <= {1'b0, r_last[TIME_W-1:1]};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == SER_LAST) begin
                        r_state <= ST_PASS2;
                    end
                end
                ST_PASS2: begin
                    r_last <= {sum_l[0], r_last[TIME_W-1:1]};
                    r_tt   <= tt_sh;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == SER_LAST) begin
                        if (win_close) begin
                            r_fc <= '0;
                            r_tt <= '0;
                            if (tt_new == '0) begin
                                r_rate  <= RATE_MAX;
                                r_state <= ST_EMIT;
                            end else begin
                                r_state <= ST_MUL;
                            end
                        end else begin
                            r_fc    <= r_fc_next;
                            r_tt    <= tt_new;
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_MUL:    r_state <= ST_DSTART;
                ST_DSTART: r_state <= ST_DWAIT;
                ST_DWAIT: begin
                    if (div_stat.done) begin
                        r_rate  <= div_quot;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sh_now  <= i_now_ms;
            r_sh_p    <= period_full;
            r_b1      <= 1'b0;
            r_b2      <= 1'b0;
            r_delay   <= '0;
            r_done    <= 1'b0;
            r_fc_next <= r_fc + 1'b1;
        end
        if (r_state == ST_PASS1) begin
            r_sh_now <= {r_sh_now[0], r_sh_now[TIME_W-1:1]};
            r_sh_el  <= {e_bit, r_sh_el[TIME_W-1:1]};
            r_sh_p   <= {1'b0, r_sh_p[DIFF_W-1:1]};
            r_b1     <= b1_n;
            r_b2     <= b2_n;
            if (r_cnt <= DIFF_LAST) begin
                r_diff <= {d_bit, r_diff[DIFF_W-1:1]};
            end
            if (r_cnt == SER_LAST) begin
                r_delay <= delay_calc;
                r_sh_d  <= delay_calc;
                r_c3    <= 2'd0;
                r_cl    <= 1'b0;
            end
        end
        if (r_state == ST_PASS2) begin
            r_sh_now <= {r_sh_now[0], r_sh_now[TIME_W-1:1]};
            r_sh_el  <= {1'b0, r_sh_el[TIME_W-1:1]};
            r_sh_d   <= {1'b0, r_sh_d[MS_W-1:1]};
            r_c3     <= sum3[2:1];
            r_cl     <= sum_l[1];
            if (r_cnt == SER_LAST) begin
                r_den  <= tt_new;
                r_done <= win_close;
            end
        end
        if (r_state == ST_MUL) begin
            r_numer <= {16'b0, MS_PER_S_Q8} * {18'b0, r_fc_next};
        end
        if (emit_go) begin
            r_out_delay <= r_delay;
            r_out_rate  <= r_rate;
            r_out_done  <= r_done;
        end
    end

    fpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (r_numer),
        .i_denom (r_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign o_in_ready        = (r_state == ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_delay_ms        = r_out_delay;
    assign o_measured_fps_q8 = r_out_rate;
    assign o_window_done     = r_out_done;

endmodule

/* hw/rtl/fpt_checker.sv */
// Port-level checks of the frame pacing timer and their binding to the top level.
`include "frame_pacing_timer_macros.svh"

module fpt_checker
    import fpt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [MS_W-1:0]   o_delay_ms,
    input logic [RATE_W-1:0] o_measured_fps_q8,
    input logic              o_window_done
);

    logic [RATE_W:0] out_rest;

    assign out_rest = {o_measured_fps_q8, o_window_done};

    `FPT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_delay_ms))
    `FPT_ASSERT_NEXT(a_rest_hold, o_out_valid && !i_out_ready, $stable(out_rest))
    `FPT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    `FPT_ASSERT_NOW(a_result_from_busy, $rose(o_out_valid), !$past(o_in_ready))

endmodule

bind frame_pacing_timer fpt_checker u_fpt_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the frame pacing timer: wait, rate and window results per request.
import fpt_pkg::*;

typedef struct packed {
    logic [MS_W-1:0]   delay_ms;
    logic [RATE_W-1:0] fps_q8;
    logic              window_done;
} t_pacing;

class pacing_scoreboard;
    logic [MS_W-1:0]   period_ms;
    logic [MS_W-1:0]   period_frac;
    logic [MS_W-1:0]   window_frames;
    logic [RATE_W-1:0] nominal_fps;
    logic              first_frame;
    logic [TIME_W-1:0] frame_start;
    logic [MS_W-1:0]   frac_accum;
    logic [MS_W-1:0]   frame_count;
    logic [TIME_W-1:0] time_total;
    logic [RATE_W-1:0] rate_q8;
    t_pacing           pending_results[$];
    int                errors;
    int                requests;
    int                restarts;
    int                windows;
    int                checked;

    function new();
        period_ms     = PERIOD_MS_RST;
        period_frac   = PERIOD_FRAC_RST;
        window_frames = WINDOW_RST;
        nominal_fps   = NOMINAL_RST;
        first_frame   = 1'b1;
        frame_start   = '0;
        frac_accum    = '0;
        frame_count   = '0;
        time_total    = '0;
        rate_q8       = NOMINAL_RST;
        errors        = 0;
        requests      = 0;
        restarts      = 0;
        windows       = 0;
        checked       = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [RATE_W-1:0] data);
        case (idx)
            CFG_PERIOD_MS: begin
                period_ms  = data[MS_W-1:0];
                frac_accum = '0;
            end
            CFG_PERIOD_FRAC: begin
                period_frac = data[MS_W-1:0];
                frac_accum  = '0;
            end
            CFG_WINDOW: window_frames = data[MS_W-1:0];
            default: nominal_fps = data;
        endcase
    endfunction

    // Advance the pacing state by one request and queue the result it must produce.
    function void take_request(logic op, logic [TIME_W-1:0] now);
        t_pacing           res;
        logic [MS_W:0]     acc_sum;
        logic [TIME_W-1:0] elapsed;
        longint            want;
        logic [MS_W-1:0]   wait_ms;
        logic [33:0]       frame_sum;
        logic [MS_W-1:0]   win;
        logic [47:0]       numer;
        logic [47:0]       quotient;
        wait_ms = '0;
        res.window_done = 1'b0;
        requests++;
        if (op == OP_RESTART) begin
            restarts++;
            first_frame = 1'b1;
            frac_accum  = '0;
            frame_count = '0;
            time_total  = '0;
            rate_q8     = nominal_fps;
            frame_start = now;
        end else if (first_frame) begin
            first_frame = 1'b0;
            frame_start = now;
        end else begin
            acc_sum    = {1'b0, frac_accum} + {1'b0, period_frac};
            want       = acc_sum[MS_W] ? 64'sd1 : 64'sd0;
            frac_accum = acc_sum[MS_W-1:0];
            elapsed    = now - frame_start;
            want       = want + longint'(period_ms) - longint'(elapsed);
            if (want > 65535)
                wait_ms = '1;
            else if (want > 0)
                wait_ms = want[MS_W-1:0];
            frame_sum   = 34'(time_total) + 34'(elapsed) + 34'(wait_ms);
            time_total  = (frame_sum > 34'hFFFF_FFFF) ? '1 : frame_sum[TIME_W-1:0];
            frame_count = frame_count + 1'b1;
            win = (window_frames == 0) ? 16'd1 : window_frames;
            if (frame_count >= win) begin
                if (time_total == 0) begin
                    rate_q8 = RATE_MAX;
                end else begin
                    numer    = 48'(MS_PER_S_Q8) * 48'(frame_count);
                    quotient = numer / 48'(time_total);
                    rate_q8  = (quotient > RATE_MAX) ? RATE_MAX : quotient[RATE_W-1:0];
                end
                frame_count     = '0;
                time_total      = '0;
                res.window_done = 1'b1;
                windows++;
            end
            frame_start = now + TIME_W'(wait_ms);
        end
        res.delay_ms = wait_ms;
        res.fps_q8   = rate_q8;
        pending_results.push_back(res);
    endfunction

    function void field_ok(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [MS_W-1:0] delay_ms, logic [RATE_W-1:0] fps_q8,
                               logic window_done);
        t_pacing exp;
        if (pending_results.size() == 0) begin
            $display("%0t: unrequested result, expected none, actual delay %0d rate %0d done %0b",
                     $time, delay_ms, fps_q8, window_done);
            errors++;
            return;
        end
        exp = pending_results.pop_front();
        checked++;
        field_ok("delay_ms", exp.delay_ms, delay_ms);
        field_ok("measured_fps_q8", exp.fps_q8, fps_q8);
        field_ok("window_done", exp.window_done, window_done);
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 280;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              i_op        = OP_FRAME;
    logic [TIME_W-1:0] i_now_ms    = '0;
    logic              i_out_ready = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [1:0]        i_cfg_idx   = CFG_PERIOD_MS;
    logic [RATE_W-1:0] i_cfg_data  = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [MS_W-1:0]   o_delay_ms;
    logic [RATE_W-1:0] o_measured_fps_q8;
    logic              o_window_done;

    pacing_scoreboard sb;
    int  send_idle_pct = 14;
    int  recv_idle_pct = 77;
    logic hold_req     = 1'b0;
    logic hold_taken   = 1'b0;
    int  hold_left     = 0;
    int  cycle_count   = 0;

    frame_pacing_timer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_now_ms          (i_now_ms),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_delay_ms        (o_delay_ms),
        .o_measured_fps_q8 (o_measured_fps_q8),
        .o_window_done     (o_window_done),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_delay_ms, o_measured_fps_q8, o_window_done);
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_req(logic op, logic [TIME_W-1:0] now);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_now_ms   <= now;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_request(op, now);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [MS_W-1:0] period_ms, logic [MS_W-1:0] period_frac,
                                logic [MS_W-1:0] window, logic [RATE_W-1:0] nominal);
        t_cfg_idx          idx;
        logic [RATE_W-1:0] data;
        for (int r = 0; r < 4; r++) begin
            idx = t_cfg_idx'(r);
            case (idx)
                CFG_PERIOD_MS:   data = RATE_W'(period_ms);
                CFG_PERIOD_FRAC: data = RATE_W'(period_frac);
                CFG_WINDOW:      data = RATE_W'(window);
                default:         data = nominal;
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= data;
            @(posedge i_clk);
            sb.write_reg(idx, data);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly frames that arrive after the previous wait ends; the rest is noise and restarts.
    task automatic random_phase(int count, int hold_at);
        int pick;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_req <= 1'b1;
            pick = $urandom_range(99);
            if (pick < 4)
                send_req(OP_RESTART, $urandom);
            else if (pick < 12)
                send_req(OP_FRAME, $urandom);
            else if (pick < 20)
                send_req(OP_FRAME, sb.frame_start - $urandom_range(0, 3));
            else
                send_req(OP_FRAME, sb.frame_start + $urandom_range(0, sb.period_ms + 4));
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(OP_FRAME, 32'd1000);
        send_req(OP_FRAME, 32'd1010);
        send_req(OP_FRAME, 32'd1016);
        send_req(OP_FRAME, 32'hFFFF_FFFF);
        send_req(OP_FRAME, 32'd4);
        send_req(OP_RESTART, 32'h8000_0000);
        send_req(OP_FRAME, 32'hFFFF_FFF0);
        send_req(OP_FRAME, 32'd2);
        settle();

        program_regs(16'hFFFF, 16'hFFFF, 16'd0, RATE_MAX);
        send_req(OP_FRAME, sb.frame_start);
        send_req(OP_FRAME, sb.frame_start);
        send_req(OP_RESTART, 32'd0);
        send_req(OP_FRAME, 32'd0);
        settle();

        program_regs(16'd0, 16'd0, 16'd3, 24'd1);
        send_req(OP_RESTART, 32'd7);
        repeat (4) send_req(OP_FRAME, 32'd7);
        send_req(OP_FRAME, 32'd8);
        settle();

        program_regs(16'd1, 16'd32768, 16'd2, NOMINAL_RST);
        repeat (6) send_req(OP_FRAME, sb.frame_start + $urandom_range(0, 2));
        settle();

        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p < 2) ? 14 : (p < 4) ? 77 : 0;
            recv_idle_pct <= (p < 2) ? 77 : (p < 4) ? 14 : 0;
            case (p)
                0: program_regs(16'd16, 16'd43690, 16'd4, NOMINAL_RST);
                1: program_regs(MS_W'($urandom_range(1, 40)), MS_W'($urandom),
                                MS_W'($urandom_range(1, 8)),
                                RATE_W'($urandom_range(1, RATE_MAX)));
                2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, RATE_MAX);
                3: program_regs(16'd0, 16'd0, 16'd1, 24'd1);
                4: program_regs(MS_W'($urandom_range(1, 100)), MS_W'($urandom),
                                MS_W'($urandom_range(1, 16)),
                                RATE_W'($urandom_range(1, RATE_MAX)));
                default: program_regs(16'd33, 16'd21845, 16'd2, 24'd7680);
            endcase
            random_phase(PHASE_ITEMS, (p == 4) ? 40 : -1);
            settle();
        end

        repeat (120) @(posedge i_clk);
        $display("Sent %0d requests (%0d restarts) over the reset defaults and nine programmed settings.",
                 sb.requests, sb.restarts);
        $display("Checked %0d results, %0d of them closing a rate window.",
                 sb.checked, sb.windows);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

/* frame_pacing_timer.f */
+incdir+hw/rtl
hw/rtl/fpt_pkg.sv
hw/rtl/fpt_div.sv
hw/rtl/frame_pacing_timer.sv
hw/rtl/fpt_checker.sv
test/testbench.sv
